@@ rtl/core/wgas_pkg.sv @@
// Shared types and constants for the weighted graph adjacency store.
// Holds the item structs, result status codes and sequencer states.
// No dependencies.
package wgas_pkg;

  // Default sizes of the store
  localparam int VERTEX_COUNT_DEF = 8;
  localparam int EDGE_SLOTS_DEF   = 36;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Fixed field widths of the items
  localparam int VERTEX_W     = 8;
  localparam int IN_WEIGHT_W  = 16;
  localparam int OUT_WEIGHT_W = 16;

  typedef enum logic {
    ACT_QUERY  = 1'b0,
    ACT_MODIFY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_ENTRY = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_DONE  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    action_t                action;
    logic [VERTEX_W-1:0]    vertex_a;
    logic [VERTEX_W-1:0]    vertex_b;
    logic [IN_WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [VERTEX_W-1:0]     neighbour;
    logic [OUT_WEIGHT_W-1:0] edge_weight;
    logic                    last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EMIT,
    S_Q_RD,
    S_Q_CHK,
    S_Q_WT,
    S_Q_END,
    S_M_RD,
    S_M_CHK,
    S_M_SCAN,
    S_M_SYM
  } state_t;

endpackage

@@ rtl/core/wgas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the pair matrix and the edge slot table. No dependencies.
module wgas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/weighted_graph_adjacency_store.sv @@
// Weighted undirected graph store: pair matrix pointing into an edge slot table.
// Depends on wgas_pkg and wgas_ram.
//
// Usage:
// - Input channel (in_valid/in_stall/in_item) takes one query or modify item.
//   in_stall stays high from acceptance until the last result of that item has
//   been loaded into the output register, so one item is worked on at a time.
// - Result channel (out_valid/out_stall/out_item) comes from an output register;
//   a new item is taken while the previous final result still waits there.
// - A query walks the matrix row of vertex_a one column at a time: each column
//   is read and checked, and a column holding an edge also fetches its weight.
//   Results come in ascending neighbour order; the final one carries last.
// - A modify reads the pair entry and then updates it. A new edge first scans
//   the slot table for the lowest free slot, one slot per cycle through the
//   shared read port.
// - An out-of-range vertex gives a single status error result.
// - After reset the block clears both tables, one entry per cycle, sweeping
//   max(VERTEX_COUNT*VERTEX_COUNT, EDGE_SLOTS) entries (64 with the defaults)
//   and stalls the input meanwhile.
// - While the receiver stalls, the result waits in the output register and
//   the sequencer holds at its next result until the register frees.
module weighted_graph_adjacency_store
  import wgas_pkg::*;
#(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int EDGE_SLOTS   = EDGE_SLOTS_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int VW         = $clog2(VERTEX_COUNT);
  localparam int PAIR_DEPTH = VERTEX_COUNT * VERTEX_COUNT;
  localparam int PAW        = $clog2(PAIR_DEPTH);
  localparam int SLOT_W     = $clog2(EDGE_SLOTS);
  localparam int PAIR_W     = 1 + SLOT_W;
  localparam int EDGE_W     = 1 + WEIGHT_BITS;
  localparam int CLR_DEPTH  = (PAIR_DEPTH > EDGE_SLOTS) ? PAIR_DEPTH : EDGE_SLOTS;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  localparam logic [VW-1:0]     COL_LAST  = VW'(VERTEX_COUNT - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(EDGE_SLOTS - 1);
  localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(CLR_DEPTH - 1);

  // Registers
  state_t                  state_r, state_nxt;
  logic [VW-1:0]           row_r, row_nxt;
  logic [VW-1:0]           col_r, col_nxt;
  logic [WEIGHT_BITS-1:0]  wt_r, wt_nxt;
  status_t                 res_r, res_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [PAIR_W-1:0]       sym_r, sym_nxt;
  logic [SLOT_W-1:0]       scan_r, scan_nxt;
  logic                    issued_all_r, issued_all_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [VERTEX_W-1:0]     pend_nb_r, pend_nb_nxt;
  logic [OUT_WEIGHT_W-1:0] pend_wt_r, pend_wt_nxt;
  logic [CLR_W-1:0]        clr_r, clr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  // RAM ports
  logic              pair_we;
  logic [PAW-1:0]    pair_waddr;
  logic [PAIR_W-1:0] pair_wdata;
  logic [PAW-1:0]    pair_raddr;
  logic [PAIR_W-1:0] pair_rdata;
  logic              edge_we;
  logic [SLOT_W-1:0] edge_waddr;
  logic [EDGE_W-1:0] edge_wdata;
  logic [SLOT_W-1:0] edge_raddr;
  logic [EDGE_W-1:0] edge_rdata;

  // Decoded values
  logic                    a_ok, b_ok;
  logic [VW-1:0]           a_idx, b_idx;
  logic [WEIGHT_BITS-1:0]  w_cut;
  logic [OUT_WEIGHT_W-1:0] wt_view;
  logic [PAW-1:0]          pa_ij, pa_ji;
  logic                    pair_vld;
  logic [SLOT_W-1:0]       pair_slot;
  logic                    out_free;
  logic [VERTEX_W-1:0]     col_nb;
  logic                    clr_pair_on, clr_edge_on;

  wgas_ram #(.WIDTH(PAIR_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  wgas_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_SLOTS)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // Check vertex range and form 0-based indexes
  assign a_ok  = (in_item.vertex_a != '0) && (in_item.vertex_a <= VERTEX_W'(VERTEX_COUNT));
  assign b_ok  = (in_item.vertex_b != '0) && (in_item.vertex_b <= VERTEX_W'(VERTEX_COUNT));
  assign a_idx = VW'(in_item.vertex_a - VERTEX_W'(1));
  assign b_idx = VW'(in_item.vertex_b - VERTEX_W'(1));

  // Cut the incoming weight to the stored width, widen the stored one for output
  for (genvar k = 0; k < WEIGHT_BITS; k++) begin : g_wcut
    if (k < IN_WEIGHT_W) begin : g_bit
      assign w_cut[k] = in_item.weight[k];
    end else begin : g_zero
      assign w_cut[k] = 1'b0;
    end
  end

  for (genvar k = 0; k < OUT_WEIGHT_W; k++) begin : g_wview
    if (k < WEIGHT_BITS) begin : g_bit
      assign wt_view[k] = edge_rdata[k];
    end else begin : g_zero
      assign wt_view[k] = 1'b0;
    end
  end

  // Matrix addresses for both orientations of the pair
  assign pa_ij = PAW'(row_r) * PAW'(VERTEX_COUNT) + PAW'(col_r);
  assign pa_ji = PAW'(col_r) * PAW'(VERTEX_COUNT) + PAW'(row_r);

  assign pair_vld  = pair_rdata[SLOT_W];
  assign pair_slot = pair_rdata[SLOT_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign col_nb    = VERTEX_W'(col_r) + VERTEX_W'(1);

  assign clr_pair_on = {1'b0, clr_r} < (CLR_W + 1)'(PAIR_DEPTH);
  assign clr_edge_on = {1'b0, clr_r} < (CLR_W + 1)'(EDGE_SLOTS);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign pair_raddr = pa_ij;

  // Sequencer: next state, RAM controls and result loading
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    wt_nxt         = wt_r;
    res_nxt        = res_r;
    slot_nxt       = slot_r;
    sym_nxt        = sym_r;
    scan_nxt       = scan_r;
    issued_all_nxt = issued_all_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_nb_nxt    = pend_nb_r;
    pend_wt_nxt    = pend_wt_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_stall ? out_valid_r : 1'b0;
    out_item_nxt   = out_item_r;

    pair_we    = 1'b0;
    pair_waddr = pa_ij;
    pair_wdata = '0;
    edge_we    = 1'b0;
    edge_waddr = slot_r;
    edge_wdata = '0;
    edge_raddr = slot_r;

    case (state_r)
      S_CLEAR: begin
        // Sweep both tables to empty
        pair_we    = clr_pair_on;
        pair_waddr = clr_r[PAW-1:0];
        edge_we    = clr_edge_on;
        edge_waddr = clr_r[SLOT_W-1:0];
        clr_nxt    = clr_r + CLR_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // Take the item and latch its operands
        if (in_valid) begin
          row_nxt        = a_idx;
          wt_nxt         = w_cut;
          pend_valid_nxt = 1'b0;
          if (in_item.action == ACT_QUERY) begin
            col_nxt = '0;
            if (a_ok) begin
              state_nxt = S_Q_RD;
            end else begin
              res_nxt   = STAT_RANGE;
              state_nxt = S_EMIT;
            end
          end else begin
            col_nxt = b_idx;
            if (a_ok && b_ok) begin
              res_nxt   = STAT_DONE;
              state_nxt = S_M_RD;
            end else begin
              res_nxt   = STAT_RANGE;
              state_nxt = S_EMIT;
            end
          end
        end
      end

      S_EMIT: begin
        // Send the single final result
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: res_r, neighbour: '0, edge_weight: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      S_Q_RD: begin
        // Pair entry read is in flight
        state_nxt = S_Q_CHK;
      end

      S_Q_CHK: begin
        // Fetch the weight of a present edge, else advance the column
        edge_raddr = pair_slot;
        if (pair_vld) begin
          slot_nxt  = pair_slot;
          state_nxt = S_Q_WT;
        end else if (col_r == COL_LAST) begin
          state_nxt = S_Q_END;
        end else begin
          col_nxt   = col_r + VW'(1);
          state_nxt = S_Q_RD;
        end
      end

      S_Q_WT: begin
        // Hold one neighbour back so the final one can carry last
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: STAT_ENTRY, neighbour: pend_nb_r,
                              edge_weight: pend_wt_r, last: 1'b0};
          end
          pend_valid_nxt = 1'b1;
          pend_nb_nxt    = col_nb;
          pend_wt_nxt    = wt_view;
          if (col_r == COL_LAST) begin
            state_nxt = S_Q_END;
          end else begin
            col_nxt   = col_r + VW'(1);
            state_nxt = S_Q_RD;
          end
        end
      end

      S_Q_END: begin
        // Flush the held neighbour as final, or report an empty list
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_item_nxt = '{status: STAT_ENTRY, neighbour: pend_nb_r,
                             edge_weight: pend_wt_r, last: 1'b1};
          end else begin
            out_item_nxt = '{status: STAT_EMPTY, neighbour: '0, edge_weight: '0, last: 1'b1};
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      S_M_RD: begin
        // Pair entry read is in flight
        state_nxt = S_M_CHK;
      end

      S_M_CHK: begin
        edge_waddr = pair_slot;
        if (wt_r == '0) begin
          // Drop the edge if present
          if (pair_vld) begin
            edge_we   = 1'b1;
            pair_we   = 1'b1;
            sym_nxt   = '0;
            state_nxt = S_M_SYM;
          end else begin
            state_nxt = S_EMIT;
          end
        end else if (pair_vld) begin
          // Update the weight in place
          edge_we    = 1'b1;
          edge_wdata = {1'b1, wt_r};
          state_nxt  = S_EMIT;
        end else begin
          // Search for the lowest free slot
          scan_nxt       = '0;
          issued_all_nxt = 1'b0;
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_M_SCAN;
        end
      end

      S_M_SCAN: begin
        edge_raddr = scan_r;
        if (chk_vld_r && !edge_rdata[WEIGHT_BITS]) begin
          // Free slot found: claim it and point the pair at it
          edge_we     = 1'b1;
          edge_waddr  = chk_idx_r;
          edge_wdata  = {1'b1, wt_r};
          pair_we     = 1'b1;
          pair_wdata  = {1'b1, chk_idx_r};
          sym_nxt     = {1'b1, chk_idx_r};
          chk_vld_nxt = 1'b0;
          state_nxt   = S_M_SYM;
        end else if (chk_vld_r && (chk_idx_r == SLOT_LAST)) begin
          // Table full: drop the new edge
          chk_vld_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end else begin
          // Advance the scan by one slot
          chk_vld_nxt = !issued_all_r;
          chk_idx_nxt = scan_r;
          if (!issued_all_r) begin
            scan_nxt = scan_r + SLOT_W'(1);
            if (scan_r == SLOT_LAST) begin
              issued_all_nxt = 1'b1;
            end
          end
        end
      end

      S_M_SYM: begin
        // Mirror the entry into the transposed pair
        pair_we    = 1'b1;
        pair_waddr = pa_ji;
        pair_wdata = sym_r;
        state_nxt  = S_EMIT;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      issued_all_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      issued_all_r <= issued_all_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    wt_r       <= wt_nxt;
    res_r      <= res_nxt;
    slot_r     <= slot_nxt;
    sym_r      <= sym_nxt;
    scan_r     <= scan_nxt;
    chk_idx_r  <= chk_idx_nxt;
    pend_nb_r  <= pend_nb_nxt;
    pend_wt_r  <= pend_wt_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef SYNTH
  // One item at a time: an accepted item blocks the input on the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // Every result other than a neighbour entry ends its item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status != STAT_ENTRY)) |-> out_item_r.last)
    else $error("non-neighbour result without last");

  // Neighbour entries name a vertex in range
  a_nb_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status == STAT_ENTRY)) |->
      ((out_item_r.neighbour != '0) &&
       (out_item_r.neighbour <= VERTEX_W'(VERTEX_COUNT))))
    else $error("neighbour out of range");

  // A held-back neighbour exists only during a query walk
  a_pend_query: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> ((state_r == S_Q_RD) || (state_r == S_Q_CHK) ||
                      (state_r == S_Q_WT) || (state_r == S_Q_END)))
    else $error("held neighbour outside a query");
`endif

endmodule

@@ tb/weighted_graph_adjacency_store_test.sv @@
// Self-checking testbench for the weighted graph adjacency store.
// Depends on wgas_pkg and weighted_graph_adjacency_store; an in-file
// scoreboard class predicts every neighbour list and modify result.
module weighted_graph_adjacency_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wgas_pkg::*;

  localparam int NV = VERTEX_COUNT_DEF;
  localparam int NS = EDGE_SLOTS_DEF;
  localparam logic [IN_WEIGHT_W-1:0] WEIGHT_MASK =
    (WEIGHT_BITS_DEF >= IN_WEIGHT_W) ? '1 : IN_WEIGHT_W'((1 << WEIGHT_BITS_DEF) - 1);

  // Graph mirror and queue of neighbour lists and modify acks still due
  class adjacency_scoreboard;
    bit                      linked      [NV][NV];
    int                      link_slot   [NV][NV];
    bit                      slot_used   [NS];
    logic [OUT_WEIGHT_W-1:0] slot_weight [NS];
    out_item_t               expected_q  [$];
    int                      mismatches;
    int                      results_checked;
    int                      queries;
    int                      modifies;
    int                      range_errors;
    int                      longest_list;

    function new();
      foreach (slot_weight[s]) slot_weight[s] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_expected(status_t st, int nb, logic [OUT_WEIGHT_W-1:0] wt, bit fin);
      out_item_t r;
      r.status      = st;
      r.neighbour   = VERTEX_W'(nb);
      r.edge_weight = wt;
      r.last        = fin;
      expected_q.push_back(r);
    endfunction

    // Apply one accepted item to the mirror and queue its results
    function void note_item(in_item_t it);
      int                     a;
      int                     b;
      int                     c;
      int                     s;
      int                     hits;
      logic [IN_WEIGHT_W-1:0] w;
      a = it.vertex_a;
      b = it.vertex_b;
      w = it.weight & WEIGHT_MASK;
      if (it.action == ACT_QUERY) begin
        queries++;
        if (a < 1 || a > NV) begin
          range_errors++;
          add_expected(STAT_RANGE, 0, '0, 1'b1);
          return;
        end
        // List the row in ascending column order
        hits = 0;
        for (c = 0; c < NV; c++) begin
          if (linked[a-1][c]) begin
            add_expected(STAT_ENTRY, c + 1, slot_weight[link_slot[a-1][c]], 1'b0);
            hits++;
          end
        end
        if (hits == 0) add_expected(STAT_EMPTY, 0, '0, 1'b1);
        else expected_q[expected_q.size()-1].last = 1'b1;
        if (hits > longest_list) longest_list = hits;
        return;
      end
      modifies++;
      if (a < 1 || a > NV || b < 1 || b > NV) begin
        range_errors++;
        add_expected(STAT_RANGE, 0, '0, 1'b1);
        return;
      end
      a--;
      b--;
      if (w == '0) begin
        // Drop the edge if present, free its slot
        if (linked[a][b]) begin
          slot_used[link_slot[a][b]]   = 1'b0;
          slot_weight[link_slot[a][b]] = '0;
          linked[a][b]    = 1'b0;
          linked[b][a]    = 1'b0;
          link_slot[a][b] = 0;
          link_slot[b][a] = 0;
        end
      end else if (linked[a][b]) begin
        slot_weight[link_slot[a][b]] = w;
      end else begin
        // Take the lowest free slot; with no free slot the edge is dropped
        s = 0;
        while (s < NS && slot_used[s]) s++;
        if (s < NS) begin
          slot_used[s]    = 1'b1;
          slot_weight[s]  = w;
          linked[a][b]    = 1'b1;
          linked[b][a]    = 1'b1;
          link_slot[a][b] = s;
          link_slot[b][a] = s;
        end
      end
      add_expected(STAT_DONE, 0, '0, 1'b1);
    endfunction

    function void report_failure(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected status %0d neighbour %0d weight %h last %0b, got status %0d neighbour %0d weight %h last %0b",
                 what, want.status, want.neighbour, want.edge_weight, want.last,
                 got.status, got.neighbour, got.edge_weight, got.last);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        report_failure("result with nothing pending", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.neighbour !== want.neighbour ||
          got.edge_weight !== want.edge_weight || got.last !== want.last)
        report_failure("result mismatch", want, got);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int idle_pct  = 0;
  int stall_pct = 0;
  int idle_plan  [4] = '{0, 73, 0, 23};
  int stall_plan [4] = '{0, 0, 73, 23};

  adjacency_scoreboard sb = new();

  weighted_graph_adjacency_store u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_item_t make_item(action_t act, int a, int b, int w);
    in_item_t it;
    it.action   = act;
    it.vertex_a = VERTEX_W'(a);
    it.vertex_b = VERTEX_W'(b);
    it.weight   = IN_WEIGHT_W'(w);
    return it;
  endfunction

  // Mostly well-formed edits and queries on a small graph, some noise
  function automatic in_item_t random_item(int add_pct);
    in_item_t it;
    int       pick;
    pick        = $urandom_range(99);
    it.action   = ACT_MODIFY;
    it.vertex_a = VERTEX_W'($urandom_range(NV, 1));
    it.vertex_b = VERTEX_W'($urandom_range(NV, 1));
    it.weight   = IN_WEIGHT_W'($urandom_range(65535, 1));
    if ($urandom_range(7) == 0) it.weight = $urandom_range(1) ? '1 : IN_WEIGHT_W'(1);
    if (pick < 8) begin
      it.action   = action_t'($urandom_range(1));
      it.vertex_a = VERTEX_W'($urandom_range(255));
      it.vertex_b = VERTEX_W'($urandom_range(255));
      it.weight   = IN_WEIGHT_W'($urandom_range(65535));
    end else if (pick < 12) begin
      it.vertex_b = $urandom_range(1) ? '0 : VERTEX_W'($urandom_range(255, NV + 1));
    end else if (pick < 40) begin
      it.action   = ACT_QUERY;
      it.vertex_b = VERTEX_W'($urandom_range(255));
    end else if (pick >= 40 + add_pct) begin
      it.weight = '0;
    end
    return it;
  endfunction

  // Offer one item after a random gap, hold it until accepted
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  // Check each accepted result, then pick the next stall
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #6_000_000;
    $display("weighted_graph_adjacency_store_test: done, errors");
    $finish;
  end

  initial begin
    int p;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty store, out-of-range vertices on both operations
    send_item(make_item(ACT_QUERY, 1, 0, 0));
    send_item(make_item(ACT_QUERY, 0, 3, 0));
    send_item(make_item(ACT_QUERY, 255, 255, 16'hffff));
    send_item(make_item(ACT_QUERY, NV + 1, 1, 1));
    send_item(make_item(ACT_MODIFY, 0, 3, 5));
    send_item(make_item(ACT_MODIFY, 4, NV + 1, 5));
    send_item(make_item(ACT_MODIFY, 255, 255, 16'hffff));
    // Inserts, self-loop, update, delete of a missing edge, slot reuse
    send_item(make_item(ACT_MODIFY, 1, 2, 16'hffff));
    send_item(make_item(ACT_MODIFY, 1, 1, 1));
    send_item(make_item(ACT_MODIFY, NV, 1, 16'h8000));
    send_item(make_item(ACT_QUERY, 1, 0, 0));
    send_item(make_item(ACT_MODIFY, 2, 1, 16'h1234));
    send_item(make_item(ACT_MODIFY, 3, 4, 0));
    send_item(make_item(ACT_MODIFY, 1, 2, 0));
    send_item(make_item(ACT_MODIFY, 5, 6, 7));
    send_item(make_item(ACT_QUERY, 1, 200, 16'h5555));
    send_item(make_item(ACT_QUERY, 2, 0, 0));
    send_item(make_item(ACT_QUERY, 6, 0, 0));
    send_item(make_item(ACT_QUERY, NV, 0, 0));
    send_item(make_item(ACT_MODIFY, NV, NV, 16'hffff));
    send_item(make_item(ACT_QUERY, NV, 0, 0));
    send_item(make_item(ACT_MODIFY, 1, 1, 0));
    send_item(make_item(ACT_QUERY, 1, 0, 0));

    // Random items under each idle and stall mix; odd phases lean to deletes
    for (p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      repeat (95) send_item(random_item((p % 2) ? 25 : 45));
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    // Drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d queries and %0d modifies (%0d out of range), %0d results checked",
             sb.queries, sb.modifies, sb.range_errors, sb.results_checked);
    $display("longest neighbour list %0d, mismatches %0d", sb.longest_list, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("weighted_graph_adjacency_store_test: done, clean");
    end else begin
      $display("weighted_graph_adjacency_store_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/wgas_pkg.sv
rtl/core/wgas_ram.sv
rtl/core/weighted_graph_adjacency_store.sv
tb/weighted_graph_adjacency_store_test.sv
